[src/hrlp_pkg.sv]
// Shared types and codes for the HTTP request line parser.
package hrlp_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] METHOD_NONE   = 3'd0;
    localparam logic [2:0] METHOD_GET    = 3'd1;
    localparam logic [2:0] METHOD_HEAD   = 3'd2;
    localparam logic [2:0] METHOD_POST   = 3'd3;
    localparam logic [2:0] METHOD_DELETE = 3'd4;

    localparam logic [1:0] VER_09 = 2'd0;
    localparam logic [1:0] VER_10 = 2'd1;
    localparam logic [1:0] VER_11 = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_NOMETHOD = 3'd2;
    localparam logic [2:0] ST_TOOLONG  = 3'd3;
    localparam logic [2:0] ST_NOHOST   = 3'd4;
    localparam logic [2:0] ST_NOPATH   = 3'd5;
    localparam logic [2:0] ST_BADVER   = 3'd6;
    localparam logic [2:0] ST_HEAD09   = 3'd7;

    typedef struct packed {
        logic [2:0]  method_code;
        logic [1:0]  version_code;
        logic        keep_alive;
        logic [2:0]  status_code;
        logic [10:0] token_length;
        logic [10:0] path_offset;
        logic        absolute_uri;
    } summary_t;

    typedef struct packed {
        logic       echo_v;
        logic [7:0] echo_byte;
        logic       sum_v;
        summary_t   sum;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_head_t;

endpackage

[src/hrlp_front.sv]
// Front end: parses request bytes and builds queue entries with echo and summary.
module hrlp_front
    import hrlp_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] line_byte,
    input  logic       line_end,
    input  logic       q_full,
    output logic       push,
    output entry_t     push_entry
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 2);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_TOKEN_LEN);

    localparam logic [3:0] SCH_HOST = 4'd8;
    localparam logic [3:0] SCH_DONE = 4'd9;
    localparam logic [3:0] SCH_FAIL = 4'd15;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_NOMETHOD,
        PH_SKIP1,
        PH_TOKEN,
        PH_SKIP2,
        PH_VERSION
    } phase_t;

    function automatic logic [7:0] meth_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0:
            begin
                case (i)
                    3'd0: c = "G";
                    3'd1: c = "E";
                    3'd2: c = "T";
                    3'd3: c = " ";
                    default: c = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (i)
                    3'd0: c = "H";
                    3'd1: c = "E";
                    3'd2: c = "A";
                    3'd3: c = "D";
                    3'd4: c = " ";
                    default: c = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (i)
                    3'd0: c = "P";
                    3'd1: c = "O";
                    3'd2: c = "S";
                    3'd3: c = "T";
                    3'd4: c = " ";
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (i)
                    3'd0: c = "D";
                    3'd1: c = "E";
                    3'd2: c = "L";
                    3'd3: c = "E";
                    3'd4: c = "T";
                    3'd5: c = "E";
                    3'd6: c = " ";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [3:0] meth_len(input logic [1:0] k);
        logic [3:0] n;
        case (k)
            2'd0: n = 4'd4;
            2'd1: n = 4'd5;
            2'd2: n = 4'd5;
            default: n = 4'd7;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] scheme_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0: c = "h";
            3'd1: c = "t";
            3'd2: c = "t";
            3'd3: c = "p";
            3'd4: c = ":";
            3'd5: c = "/";
            3'd6: c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ver_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0: c = "H";
            3'd1: c = "T";
            3'd2: c = "T";
            3'd3: c = "P";
            3'd4: c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] dec_sat(input logic [3:0] v, input logic [3:0] d);
        logic [7:0] t;
        t = ({4'd0, v} * 8'd10) + {4'd0, d};
        return (t > 8'd15) ? 4'd15 : t[3:0];
    endfunction

    phase_t           phase_reg, phase_next;
    logic [2:0]       line_count_reg, line_count_next;
    logic [3:0]       cand_reg, cand_next;
    logic [2:0]       found_reg, found_next;
    logic [CNT_W-1:0] tok_count_reg, tok_count_next;
    logic [3:0]       sch_reg, sch_next;
    logic [CNT_W-1:0] hpo_reg, hpo_next;
    logic             nohost_reg, nohost_next;
    logic             path_reg, path_next;
    logic             term_reg, term_next;
    logic [3:0]       vphase_reg, vphase_next;
    logic [3:0]       major_reg, major_next;
    logic [3:0]       minor_reg, minor_next;
    logic             vbad_reg, vbad_next;

    logic             accept;
    logic             echo_v;
    summary_t         sum;

    logic [3:0]       vs_phase;
    logic [3:0]       vs_major;
    logic [3:0]       vs_minor;
    logic             vs_bad;

    assign accept = byte_valid && !q_full;

    // Version text step, applied in the phases that read version bytes.
    always_comb
    begin
        logic dig;
        dig = (line_byte >= "0") && (line_byte <= "9");
        vs_phase = vphase_reg;
        vs_major = major_reg;
        vs_minor = minor_reg;
        vs_bad   = vbad_reg;
        if (!vbad_reg && vphase_reg < 4'd9)
        begin
            if (vphase_reg < 4'd5)
            begin
                if (line_byte == ver_char(vphase_reg[2:0]))
                    vs_phase = vphase_reg + 4'd1;
                else
                    vs_bad = 1'b1;
            end
            else if (vphase_reg == 4'd5 || vphase_reg == 4'd6)
            begin
                if (dig)
                begin
                    vs_major = dec_sat(major_reg, line_byte[3:0]);
                    vs_phase = 4'd6;
                end
                else if (vphase_reg == 4'd6 && line_byte == CH_DOT)
                    vs_phase = 4'd7;
                else
                    vs_bad = 1'b1;
            end
            else if (vphase_reg == 4'd7)
            begin
                if (dig)
                begin
                    vs_minor = dec_sat(minor_reg, line_byte[3:0]);
                    vs_phase = 4'd8;
                end
                else
                    vs_bad = 1'b1;
            end
            else
            begin
                if (dig)
                    vs_minor = dec_sat(minor_reg, line_byte[3:0]);
                else
                    vs_phase = 4'd9;
            end
        end
    end

    always_comb
    begin
        logic [2:0]       idx;
        logic             abs_uri;
        logic [1:0]       ver;
        logic [2:0]       st;
        logic [CNT_W+10:0] tl_ext;
        logic [CNT_W+10:0] po_ext;

        phase_next      = phase_reg;
        line_count_next = line_count_reg;
        cand_next       = cand_reg;
        found_next      = found_reg;
        tok_count_next  = tok_count_reg;
        sch_next        = sch_reg;
        hpo_next        = hpo_reg;
        nohost_next     = nohost_reg;
        path_next       = path_reg;
        term_next       = term_reg;
        vphase_next     = vphase_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        vbad_next       = vbad_reg;
        echo_v          = 1'b0;
        idx             = line_count_reg;

        if (!term_reg)
        begin
            if (line_byte == 8'h00)
                term_next = 1'b1;
            else
            begin
                if (line_count_reg < 3'd7)
                    line_count_next = line_count_reg + 3'd1;
                case (phase_reg)
                    PH_METHOD:
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            if (cand_reg[k])
                            begin
                                if ({1'b0, idx} < meth_len(2'(k))
                                    && line_byte == meth_char(2'(k), idx))
                                begin
                                    if ({1'b0, idx} + 4'd1 == meth_len(2'(k)))
                                    begin
                                        found_next = 3'(k + 1);
                                        phase_next = PH_SKIP1;
                                    end
                                end
                                else
                                    cand_next[k] = 1'b0;
                            end
                        end
                        if (phase_next == PH_METHOD && cand_next == 4'd0)
                            phase_next = PH_NOMETHOD;
                    end
                    PH_SKIP1, PH_TOKEN:
                    begin
                        if (line_byte == CH_SPACE)
                        begin
                            if (phase_reg == PH_TOKEN)
                                phase_next = PH_SKIP2;
                        end
                        else
                        begin
                            phase_next = PH_TOKEN;
                            echo_v = 1'b1;
                            if (tok_count_reg <= MAX_C)
                                tok_count_next = tok_count_reg + CNT_W'(1);
                            if (sch_reg < 4'd7)
                            begin
                                if (line_byte == scheme_char(sch_reg[2:0]))
                                    sch_next = sch_reg + 4'd1;
                                else
                                    sch_next = SCH_FAIL;
                            end
                            else if (sch_reg == 4'd7)
                            begin
                                if (line_byte == CH_SLASH)
                                begin
                                    nohost_next = 1'b1;
                                    sch_next = SCH_DONE;
                                end
                                else
                                    sch_next = SCH_HOST;
                            end
                            else if (sch_reg == SCH_HOST && line_byte == CH_SLASH)
                            begin
                                path_next = 1'b1;
                                hpo_next = (tok_count_reg > MAX_C) ? MAX_C : tok_count_reg;
                                sch_next = SCH_DONE;
                            end
                        end
                    end
                    PH_SKIP2:
                    begin
                        if (line_byte != CH_SPACE)
                        begin
                            phase_next  = PH_VERSION;
                            vphase_next = vs_phase;
                            major_next  = vs_major;
                            minor_next  = vs_minor;
                            vbad_next   = vs_bad;
                        end
                    end
                    PH_VERSION:
                    begin
                        vphase_next = vs_phase;
                        major_next  = vs_major;
                        minor_next  = vs_minor;
                        vbad_next   = vs_bad;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // The summary is judged on the state after this byte.
        abs_uri = (sch_next >= 4'd7) && (sch_next <= SCH_DONE);
        ver = VER_09;
        st = ST_OK;
        if (line_count_next < 3'd5)
            st = ST_SHORT;
        else if (found_next == METHOD_NONE)
            st = ST_NOMETHOD;
        else if (tok_count_next > MAX_C)
            st = ST_TOOLONG;
        else if (abs_uri && (sch_next == 4'd7 || nohost_next))
            st = ST_NOHOST;
        else if (abs_uri && sch_next == SCH_HOST)
            st = ST_NOPATH;
        else
        begin
            if (phase_next == PH_VERSION)
            begin
                if (vbad_next || vphase_next < 4'd8)
                    st = ST_BADVER;
                else if (major_next == 4'd0 && minor_next == 4'd9)
                    ver = VER_09;
                else if (major_next == 4'd1 && minor_next == 4'd0)
                    ver = VER_10;
                else if (major_next == 4'd1 && minor_next == 4'd1)
                    ver = VER_11;
                else
                    st = ST_BADVER;
            end
            if (st == ST_OK && found_next == METHOD_HEAD && ver == VER_09)
                st = ST_HEAD09;
        end

        tl_ext = {11'd0, tok_count_next};
        po_ext = {11'd0, hpo_next};
        sum = '0;
        sum.status_code = st;
        if (st >= ST_TOOLONG)
        begin
            sum.method_code  = found_next;
            sum.token_length = tl_ext[10:0];
            sum.absolute_uri = abs_uri;
        end
        if (path_next && (st == ST_OK || st >= ST_BADVER))
            sum.path_offset = po_ext[10:0];
        if (st == ST_OK || st == ST_HEAD09)
        begin
            sum.version_code = ver;
            sum.keep_alive   = (ver == VER_11);
        end

        if (line_end)
        begin
            phase_next      = PH_METHOD;
            line_count_next = 3'd0;
            cand_next       = 4'hF;
            found_next      = METHOD_NONE;
            tok_count_next  = '0;
            sch_next        = 4'd0;
            hpo_next        = '0;
            nohost_next     = 1'b0;
            path_next       = 1'b0;
            term_next       = 1'b0;
            vphase_next     = 4'd0;
            major_next      = 4'd0;
            minor_next      = 4'd0;
            vbad_next       = 1'b0;
        end
    end

    assign push = accept && (echo_v || line_end);

    always_comb
    begin
        push_entry.echo_v    = echo_v;
        push_entry.echo_byte = line_byte;
        push_entry.sum_v     = line_end;
        push_entry.sum       = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_METHOD;
            line_count_reg <= 3'd0;
            cand_reg       <= 4'hF;
            found_reg      <= METHOD_NONE;
            tok_count_reg  <= '0;
            sch_reg        <= 4'd0;
            hpo_reg        <= '0;
            nohost_reg     <= 1'b0;
            path_reg       <= 1'b0;
            term_reg       <= 1'b0;
            vphase_reg     <= 4'd0;
            major_reg      <= 4'd0;
            minor_reg      <= 4'd0;
            vbad_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            line_count_reg <= line_count_next;
            cand_reg       <= cand_next;
            found_reg      <= found_next;
            tok_count_reg  <= tok_count_next;
            sch_reg        <= sch_next;
            hpo_reg        <= hpo_next;
            nohost_reg     <= nohost_next;
            path_reg       <= path_next;
            term_reg       <= term_next;
            vphase_reg     <= vphase_next;
            major_reg      <= major_next;
            minor_reg      <= minor_next;
            vbad_reg       <= vbad_next;
        end
    end

endmodule

[src/hrlp_queue.sv]
// Short entry queue between the parsing front end and the result back end.
module hrlp_queue
    import hrlp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output logic    full,
    output q_head_t head
);

    entry_t            mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

endmodule

[src/hrlp_back.sv]
// Back end: turns queue entries into echo and summary results in an output register.
module hrlp_back
    import hrlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_head_t     head,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [7:0]  token_byte,
    output logic        run_last,
    output summary_t    sum_out
);

    logic     valid_reg, valid_next;
    logic     echo_done_reg, echo_done_next;
    logic     kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic     last_reg, last_next;
    summary_t sum_reg, sum_next;
    logic     load_ok;

    assign load_ok = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next     = valid_reg;
        echo_done_next = echo_done_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        pop            = 1'b0;
        if (load_ok)
        begin
            valid_next = head.valid;
            if (head.valid)
            begin
                if (head.entry.echo_v && !echo_done_reg)
                begin
                    kind_next = 1'b0;
                    byte_next = head.entry.echo_byte;
                    last_next = !head.entry.sum_v;
                    sum_next  = '0;
                    if (head.entry.sum_v)
                        echo_done_next = 1'b1;
                    else
                        pop = 1'b1;
                end
                else
                begin
                    kind_next      = 1'b1;
                    byte_next      = 8'd0;
                    last_next      = 1'b1;
                    sum_next       = head.entry.sum;
                    echo_done_next = 1'b0;
                    pop            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            echo_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            echo_done_reg <= echo_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        sum_reg  <= sum_next;
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign token_byte   = byte_reg;
    assign run_last     = last_reg;
    assign sum_out      = sum_reg;

endmodule

[src/http_request_line_parser.sv]
// Top level of the HTTP request line parser.
// Path: a request byte goes through the queue into the back end's output register.
// Throughput: one request byte per cycle unless byte_stall; results leave one per cycle
// unless result_stall; a four-entry queue absorbs a line-ending token's echo and summary.
// Reset: asynchronous, active low; clears the parser state, the queue and the output valid.
module http_request_line_parser
    import hrlp_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  line_byte,
    input  logic        line_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [7:0]  token_byte,
    output logic        run_last,
    output logic [2:0]  method_code,
    output logic [1:0]  version_code,
    output logic        keep_alive,
    output logic [2:0]  status_code,
    output logic [10:0] token_length,
    output logic [10:0] path_offset,
    output logic        absolute_uri
);

    logic     q_full;
    logic     push;
    entry_t   push_entry;
    logic     pop;
    q_head_t  q_head;
    summary_t sum_out;

    assign byte_stall = q_full;

    hrlp_front #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .line_byte (line_byte),
        .line_end  (line_end),
        .q_full    (q_full),
        .push      (push),
        .push_entry(push_entry)
    );

    hrlp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .full      (q_full),
        .head      (q_head)
    );

    hrlp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .pop         (pop),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .kind        (kind),
        .token_byte  (token_byte),
        .run_last    (run_last),
        .sum_out     (sum_out)
    );

    assign method_code  = sum_out.method_code;
    assign version_code = sum_out.version_code;
    assign keep_alive   = sum_out.keep_alive;
    assign status_code  = sum_out.status_code;
    assign token_length = sum_out.token_length;
    assign path_offset  = sum_out.path_offset;
    assign absolute_uri = sum_out.absolute_uri;

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind |-> run_last)
        else $error("summary result without run_last");

    a_echo_then_summary: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !kind && !run_last |=> !result_valid || kind)
        else $error("echo on the last byte not followed by its summary");

    a_echo_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !kind |-> status_code == ST_OK && method_code == METHOD_NONE
            && token_length == 11'd0)
        else $error("echo result carries summary fields");

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> q_head.valid)
        else $error("request stalled with an empty queue");

endmodule
